// ----- sv/tks_pkg.sv -----
// Shared types, constants and helpers for the top-k score table.
`default_nettype none
package tks_pkg;

  localparam int CAPACITY  = 10;
  localparam int KEY_WIDTH = 32;
  localparam int FKEY_W    = 32;
  localparam int SCORE_W   = 32;
  localparam int RANK_W    = 4;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_READOUT = 2'd2;

  typedef struct packed {
    logic [1:0]                operation;
    logic [FKEY_W-1:0]         player_key;
    logic signed [SCORE_W-1:0] player_score;
  } tks_in_t;

  typedef struct packed {
    logic                      entry_valid;
    logic [FKEY_W-1:0]         entry_key;
    logic signed [SCORE_W-1:0] entry_score;
    logic [RANK_W-1:0]         entry_rank;
    logic                      last_of_run;
  } tks_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_WRITE,
    ST_LK_SCAN,
    ST_MISS,
    ST_SORT,
    ST_RD_EMIT
  } tks_state_t;

  typedef struct packed {
    logic capture;
    logic append;
    logic idx_inc;
    logic idx_clr;
    logic scan_min;
    logic replace;
    logic sort_step;
    logic emit_hit;
    logic emit_miss;
    logic emit_entry;
  } tks_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic idx_last_scan;
    logic idx_last_cnt;
    logic hit;
    logic out_free;
  } tks_sts_t;

  // Keep the low KEY_WIDTH bits of a port key.
  function automatic logic [KEY_WIDTH-1:0] key_in(input logic [FKEY_W-1:0] k);
    logic [63:0] t;
    t = 64'(k);
    return t[KEY_WIDTH-1:0];
  endfunction

  function automatic logic [FKEY_W-1:0] key_out(input logic [KEY_WIDTH-1:0] k);
    logic [63:0] t;
    t = 64'(k);
    return t[FKEY_W-1:0];
  endfunction

  function automatic logic [RANK_W-1:0] to_rank(input logic [IDX_W-1:0] idx);
    logic [31:0] t;
    t = 32'(idx);
    return t[RANK_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/top_k_score_table.sv -----
// Top-k score table: holds up to CAPACITY key/score pairs, ranked readout on request.
//
// Input channel (in_valid/in_ready/in_data) takes one transaction at a time:
//   insert  - while not full, appended in the accept cycle; when full, a
//             scan of all CAPACITY entries finds the lowest-indexed minimum, then the
//             ST_INS_WRITE state replaces it if the new score is strictly higher.
//   lookup  - scans stored entries one per cycle; one result, found or not found.
//   readout - odd-even transposition sort over the stored entries (stable,
//             descending), then one result per entry per cycle, last one marked.
//             An empty table gives one not-found result.
// Throughput is set by the single store read port walked by the scan index; a new
// transaction is accepted only in the idle state, after the previous one is done.
// Results leave through an output register (out_valid/out_ready/out_data); the
// sequencer holds while that register is full and not taken, so a stalled
// receiver pauses the scan or readout without loss.
// Reset (rst_n low, synchronous) empties the table and drops any pending result.
`default_nettype none
module top_k_score_table import tks_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tks_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tks_out_t out_data
);

  tks_cmd_t cmd;
  tks_sts_t sts;

  tks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tks_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_hit || cmd.emit_miss || cmd.emit_entry) |-> sts.out_free)
    else $error("result loaded while output register still held");

  a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> !sts.full)
    else $error("append into a full table");

  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_hit, cmd.emit_miss, cmd.emit_entry}))
    else $error("more than one result source in a cycle");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_min || cmd.sort_step || cmd.replace) |-> !in_ready)
    else $error("input ready while a transaction is in progress");
`endif

endmodule
`default_nettype wire

// ----- sv/tks_ctrl.sv -----
// Sequencer for insert, lookup and ranked readout transactions.
`default_nettype none
module tks_ctrl import tks_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  input  tks_sts_t   sts,
  output tks_cmd_t   cmd
);

  tks_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_INSERT:  if (sts.full) state_nxt = ST_INS_SCAN;
            OP_LOOKUP:  state_nxt = sts.empty ? ST_MISS : ST_LK_SCAN;
            OP_READOUT: state_nxt = sts.empty ? ST_MISS : ST_SORT;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INS_SCAN:  if (sts.idx_last_scan) state_nxt = ST_INS_WRITE;
      ST_INS_WRITE: state_nxt = ST_IDLE;
      ST_LK_SCAN: begin
        if (sts.hit) begin
          if (sts.out_free) state_nxt = ST_IDLE;
        end else if (sts.idx_last_cnt) begin
          state_nxt = ST_MISS;
        end
      end
      ST_MISS:    if (sts.out_free) state_nxt = ST_IDLE;
      ST_SORT:    if (sts.idx_last_scan) state_nxt = ST_RD_EMIT;
      ST_RD_EMIT: if (sts.out_free && sts.idx_last_cnt) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.append  = (in_op == OP_INSERT) && !sts.full;
        end
      end
      ST_INS_SCAN: begin
        cmd.scan_min = 1'b1;
        cmd.idx_inc  = !sts.idx_last_scan;
      end
      ST_INS_WRITE: cmd.replace = 1'b1;
      ST_LK_SCAN: begin
        if (sts.hit) begin
          cmd.emit_hit = sts.out_free;
        end else begin
          cmd.idx_inc = !sts.idx_last_cnt;
        end
      end
      ST_MISS: cmd.emit_miss = sts.out_free;
      ST_SORT: begin
        cmd.sort_step = 1'b1;
        cmd.idx_clr   = sts.idx_last_scan;
        cmd.idx_inc   = !sts.idx_last_scan;
      end
      ST_RD_EMIT: begin
        cmd.emit_entry = sts.out_free;
        cmd.idx_inc    = sts.out_free && !sts.idx_last_cnt;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/tks_datapath.sv -----
// Entry store, scan index, minimum tracker, sort network and result register.
`default_nettype none
module tks_datapath import tks_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tks_cmd_t cmd,
  input  tks_in_t  in_data,
  output tks_sts_t sts,
  input  logic     out_ready,
  output logic     out_valid,
  output tks_out_t out_data
);

  logic [KEY_WIDTH-1:0]      key_mem_r   [CAPACITY];
  logic signed [SCORE_W-1:0] score_mem_r [CAPACITY];
  logic [KEY_WIDTH-1:0]      key_mem_nxt   [CAPACITY];
  logic signed [SCORE_W-1:0] score_mem_nxt [CAPACITY];

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [KEY_WIDTH-1:0]      key_r;
  logic signed [SCORE_W-1:0] score_r;
  logic [IDX_W-1:0]          min_idx_r;
  logic signed [SCORE_W-1:0] min_score_r;
  logic                      out_valid_r, out_valid_nxt;
  tks_out_t                  out_data_r, out_data_nxt;

  logic [KEY_WIDTH-1:0]      rd_key;
  logic signed [SCORE_W-1:0] rd_score;
  logic                      emit;

  assign rd_key   = key_mem_r[idx_r];
  assign rd_score = score_mem_r[idx_r];
  assign emit     = cmd.emit_hit || cmd.emit_miss || cmd.emit_entry;

  assign sts.full          = (count_r == CNT_W'(CAPACITY));
  assign sts.empty         = (count_r == '0);
  assign sts.idx_last_scan = (idx_r == IDX_W'(CAPACITY - 1));
  assign sts.idx_last_cnt  = ((CNT_W'(idx_r) + 1'b1) == count_r);
  assign sts.hit           = (rd_key == key_r);
  assign sts.out_free      = !out_valid_r || out_ready;

  // Store updates: append, conditional replace, one odd-even transposition phase.
  // Swapping only on strictly lower score keeps equal scores in stored order.
  always_comb begin
    key_mem_nxt   = key_mem_r;
    score_mem_nxt = score_mem_r;
    if (cmd.append) begin
      key_mem_nxt[count_r[IDX_W-1:0]]   = key_in(in_data.player_key);
      score_mem_nxt[count_r[IDX_W-1:0]] = in_data.player_score;
    end
    if (cmd.replace && (min_score_r < score_r)) begin
      key_mem_nxt[min_idx_r]   = key_r;
      score_mem_nxt[min_idx_r] = score_r;
    end
    if (cmd.sort_step) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if ((1'(i) == idx_r[0]) && (CNT_W'(i + 1) < count_r) &&
            (score_mem_r[i] < score_mem_r[i+1])) begin
          key_mem_nxt[i]     = key_mem_r[i+1];
          key_mem_nxt[i+1]   = key_mem_r[i];
          score_mem_nxt[i]   = score_mem_r[i+1];
          score_mem_nxt[i+1] = score_mem_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    key_mem_r   <= key_mem_nxt;
    score_mem_r <= score_mem_nxt;
  end

  assign count_nxt = cmd.append ? count_r + 1'b1 : count_r;

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.capture || cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    idx_r <= idx_nxt;
    if (cmd.capture) begin
      key_r   <= key_in(in_data.player_key);
      score_r <= in_data.player_score;
    end
    // First entry seeds the minimum; later ones win only on a strictly lower score.
    if (cmd.scan_min && ((idx_r == '0) || (rd_score < min_score_r))) begin
      min_idx_r   <= idx_r;
      min_score_r <= rd_score;
    end
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (cmd.emit_miss) begin
      out_data_nxt             = '0;
      out_data_nxt.last_of_run = 1'b1;
    end else if (cmd.emit_hit || cmd.emit_entry) begin
      out_data_nxt.entry_valid = 1'b1;
      out_data_nxt.entry_key   = key_out(rd_key);
      out_data_nxt.entry_score = rd_score;
      out_data_nxt.entry_rank  = cmd.emit_entry ? to_rank(idx_r) : '0;
      out_data_nxt.last_of_run = cmd.emit_hit || sts.idx_last_cnt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
